[src/grm_pkg.sv]
`timescale 1ns / 1ps
// Package for the greedy rectangle merge unit.
// Mask size, transaction structs, operation codes and controller/datapath command types.
package grm_pkg;

    localparam int MASK_SIDE = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [4:0]  cell_u;
        logic [4:0]  cell_v;
        logic [31:0] material;
        logic [1:0]  surface_class;
        logic [19:0] light_word;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  rect_u;
        logic [4:0]  rect_v;
        logic [5:0]  rect_width;
        logic [5:0]  rect_height;
        logic [31:0] rect_material;
        logic [1:0]  rect_surface;
        logic [19:0] rect_light;
        logic        done_res;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic init_step;   // clear one material entry after reset
        logic wr_item;     // write input cell
        logic scan_start;  // load scan pointer, issue read
        logic scan_step;   // examine read data at scan pointer
        logic key_latch;   // latch keys at found cell
        logic run_step;    // examine next cell along u
        logic row_start;   // begin a row of the v growth
        logic row_step;    // examine cell of current row
        logic clr_start;   // begin clearing pass
        logic clr_step;    // clear one cell
        logic emit_rect;
        logic emit_done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_last;   // last entry of the post-reset clear
        logic scan_hit;    // non-empty cell at scan pointer
        logic scan_end;    // scan ran off the mask
        logic run_stop;    // span along u ended
        logic row_fail;    // row mismatch
        logic row_last;    // row fully matched
        logic grow_end;    // no more rows below
        logic clr_last;
    } t_sts;

endpackage

[src/greedy_rectangle_merge_unit.sv]
`timescale 1ns / 1ps
// After reset every entry of the material RAM is cleared before the first transaction
// is taken. Writes can follow back to back. A fetch scans from the scan pointer to the
// first non-empty cell, grows a span along u, adds rows below while each matches it,
// clears the merged cells and emits the rectangle; a fetch that finds nothing emits a
// done result. The mask RAM has a single read port and is walked one cell per cycle.
// The result is held in an output register; writes and the next fetch are taken while
// it waits, but no new result is loaded until it is drained.
// Depends on grm_pkg, grm_ctrl, grm_datapath and grm_ram.
module greedy_rectangle_merge_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  grm_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output grm_pkg::t_out_item  o_data
);
    import grm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    grm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_data.operation), .o_valid(o_valid), .i_ready(i_ready),
        .i_sts(sts), .o_cmd(cmd));

    grm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_data), .i_cmd(cmd),
        .o_sts(sts), .o_res(o_data));
endmodule

[src/grm_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module grm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/grm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: mask memories, scan and merge counters, result register.
// Depends on grm_pkg and grm_ram.
module grm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grm_pkg::t_in_item  i_item,
    input  grm_pkg::t_cmd      i_cmd,
    output grm_pkg::t_sts      o_sts,
    output grm_pkg::t_out_item o_res
);
    import grm_pkg::*;

    localparam int CW = $clog2(MASK_SIDE);
    localparam int AW = 2 * CW;
    localparam int CELLS = MASK_SIDE * MASK_SIDE;
    localparam int SW = CW + 1;

    logic [CW-1:0] r_u, r_v;
    logic [SW-1:0] r_w, r_h, r_i;
    logic [CW:0]   r_row;    // current row being compared / cleared (v + h)
    logic [AW:0]   r_pos;    // scan pointer, up to CELLS
    logic [AW-1:0] r_init;   // material entry cleared after reset
    logic [31:0]   r_mat;
    logic [1:0]    r_surf;
    logic [19:0]   r_light;
    t_out_item     r_res;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          key_we, mat_we;
    logic [31:0]   mat_q, mat_wd;
    logic [1:0]    surf_q;
    logic [19:0]   light_q;
    logic [AW-1:0] r_raddr;
    logic          wr_in_range, match;
    logic [CW:0]   col_next, row_next;
    logic [AW-1:0] cell_addr;

    assign wr_in_range = ({1'b0, i_item.cell_u} < (CW+1)'(MASK_SIDE)) &&
                         ({1'b0, i_item.cell_v} < (CW+1)'(MASK_SIDE));

    // address of cell (row, u + i) used for the clear sweep
    assign cell_addr = {r_row[CW-1:0], CW'(r_u + r_i[CW-1:0])};

    // read data always belongs to the cell under test; the next one is prefetched
    always_comb begin
        rd_addr = r_raddr;
        if (i_cmd.scan_start) begin
            rd_addr = (r_pos >= (AW+1)'(CELLS)) ? '0 : r_pos[AW-1:0];
        end else if (i_cmd.row_start) begin
            rd_addr = {row_next[CW-1:0], r_u};
        end
    end

    assign key_we = i_cmd.wr_item && wr_in_range;
    assign mat_we = key_we || i_cmd.clr_step || i_cmd.init_step;

    always_comb begin
        if (i_cmd.init_step) begin
            wr_addr = r_init;
        end else if (i_cmd.clr_step) begin
            wr_addr = cell_addr;
        end else begin
            wr_addr = {i_item.cell_v[CW-1:0], i_item.cell_u[CW-1:0]};
        end
    end

    // material 0 marks an empty cell, so clearing writes zero
    assign mat_wd = key_we ? i_item.material : '0;

    grm_ram #(.WIDTH(32), .DEPTH(CELLS)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(wr_addr),
        .i_wdata(mat_wd), .i_raddr(rd_addr), .o_rdata(mat_q));
    grm_ram #(.WIDTH(2), .DEPTH(CELLS)) u_surf (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(wr_addr),
        .i_wdata(i_item.surface_class), .i_raddr(rd_addr), .o_rdata(surf_q));
    grm_ram #(.WIDTH(20), .DEPTH(CELLS)) u_light (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(wr_addr),
        .i_wdata(i_item.light_word), .i_raddr(rd_addr), .o_rdata(light_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_cmd.init_step) begin
            r_init <= r_init + AW'(1);
        end
    end

    assign match = (mat_q == r_mat) && (surf_q == r_surf) && (light_q == r_light);

    assign col_next = (CW+1)'(r_u) + (CW+1)'(r_i) + (CW+1)'(1);
    assign row_next = r_row + (CW+1)'(1);

    // next read address for each sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start || i_cmd.row_start) begin
            r_raddr <= rd_addr + AW'(1);
        end else if (i_cmd.key_latch) begin
            r_raddr <= r_pos[AW-1:0] + AW'(2);
        end else if (i_cmd.scan_step || i_cmd.row_step || i_cmd.run_step) begin
            r_raddr <= r_raddr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.scan_start) begin
            r_pos <= (r_pos >= (AW+1)'(CELLS)) ? (AW+1)'(CELLS) : r_pos;
        end else if (i_cmd.scan_step) begin
            r_pos <= r_pos + (AW+1)'(1);
        end else if (i_cmd.emit_done) begin
            r_pos <= '0;
        end else if (i_cmd.emit_rect) begin
            r_pos <= r_pos + (AW+1)'(r_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_latch) begin
            r_mat   <= mat_q;
            r_surf  <= surf_q;
            r_light <= light_q;
            r_u     <= r_pos[CW-1:0];
            r_v     <= r_pos[AW-1:CW];
            r_row   <= {1'b0, r_pos[AW-1:CW]};
            r_w     <= SW'(1);
            r_h     <= SW'(1);
            r_i     <= '0;
        end else if (i_cmd.run_step && !o_sts.run_stop) begin
            r_w <= r_w + SW'(1);
            r_i <= r_i + SW'(1);
        end else if (i_cmd.row_start) begin
            r_row <= row_next;
            r_i   <= '0;
        end else if (i_cmd.row_step) begin
            if (o_sts.row_last) begin
                r_h <= r_h + SW'(1);
            end
            r_i <= r_i + SW'(1);
        end else if (i_cmd.clr_start) begin
            r_row <= {1'b0, r_v};
            r_i   <= '0;
        end else if (i_cmd.clr_step) begin
            if (r_i == r_w - SW'(1)) begin
                r_i   <= '0;
                r_row <= row_next;
            end else begin
                r_i <= r_i + SW'(1);
            end
        end
    end

    assign o_sts.init_last = (r_init == AW'(CELLS - 1));
    assign o_sts.scan_hit  = (mat_q != 32'd0);
    assign o_sts.scan_end  = (r_pos >= (AW+1)'(CELLS));
    assign o_sts.run_stop  = !match || (col_next >= (CW+1)'(MASK_SIDE));
    assign o_sts.row_fail  = !match;
    assign o_sts.row_last  = match && (r_i == r_w - SW'(1));
    assign o_sts.grow_end  = (row_next >= (CW+1)'(MASK_SIDE));
    assign o_sts.clr_last  = (r_i == r_w - SW'(1)) &&
                             (r_row == (CW+1)'(r_v) + (CW+1)'(r_h) - (CW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_done) begin
            r_res.rect_u        <= '0;
            r_res.rect_v        <= '0;
            r_res.rect_width    <= '0;
            r_res.rect_height   <= '0;
            r_res.rect_material <= '0;
            r_res.rect_surface  <= '0;
            r_res.rect_light    <= '0;
            r_res.done_res      <= 1'b1;
        end else if (i_cmd.emit_rect) begin
            r_res.rect_u        <= 5'(r_u);
            r_res.rect_v        <= 5'(r_v);
            r_res.rect_width    <= 6'(r_w);
            r_res.rect_height   <= 6'(r_h);
            r_res.rect_material <= r_mat;
            r_res.rect_surface  <= r_surf;
            r_res.rect_light    <= r_light;
            r_res.done_res      <= 1'b0;
        end
    end

    assign o_res = r_res;

`ifndef ASSERT_OFF
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rect |-> (r_w != '0) && (r_w <= SW'(MASK_SIDE)))
        else $error("width out of range");
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rect |-> (r_h != '0) && (r_h <= SW'(MASK_SIDE)))
        else $error("height out of range");
    a_done_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_done |=> (r_pos == '0))
        else $error("scan not rewound");
`endif
endmodule

[src/grm_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM for the greedy rectangle merge unit.
// Depends on grm_pkg.
module grm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    output logic              o_valid,
    input  logic              i_ready,
    input  grm_pkg::t_sts     i_sts,
    output grm_pkg::t_cmd     o_cmd
);
    import grm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;  // material clear after reset
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_RUN   = 4'd3;
    localparam logic [3:0] S_ROWS  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_CLR   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       acc;

    // a waiting result only holds back the emit, not the next transaction
    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.wr_item = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_hit) begin
                    o_cmd.key_latch = 1'b1;
                    n_state = S_RUN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_RUN: begin
                o_cmd.run_step = 1'b1;
                if (i_sts.run_stop) begin
                    n_state = S_ROWS;
                end
            end
            S_ROWS: begin
                if (i_sts.grow_end) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else begin
                    o_cmd.row_start = 1'b1;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.row_step = 1'b1;
                if (i_sts.row_fail) begin
                    o_cmd.row_step  = 1'b0;
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else if (i_sts.row_last) begin
                    n_state = S_ROWS;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!n_ovalid) begin
                    o_cmd.emit_rect = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DONE: begin
                if (!n_ovalid) begin
                    o_cmd.emit_done = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef ASSERT_OFF
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_rect && o_cmd.emit_done))
        else $error("double emit");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_rect || o_cmd.emit_done) |=> r_ovalid)
        else $error("result lost");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
`endif
endmodule
